@@ design/pid_controller_clamped_top_assert.svh @@
// Assertion macros for the top-level design file.
// With SYNTHESIS defined, every macro expands to nothing.
`ifndef PID_CONTROLLER_CLAMPED_TOP_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge and skipped while reset is high.
`define PCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCC_ASSERT(label, clk, rst, prop, msg)
`define PCC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ design/pcc_pkg.sv @@
package pcc_pkg;

   // Fraction bits of the gains and of the integral.
   localparam int GAIN_FRAC_BITS = 16;

   localparam int GAIN_W     = 32;
   localparam int DATA_W     = 16;
   localparam int TIME_W     = 32;
   localparam int STIME_W    = 16;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int PROD_W     = GAIN_W + DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int ACC_W      = PROD_W + 2;
   localparam int INTEG_W    = DATA_W + GAIN_FRAC_BITS;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP,
      CSR_KI_TIMES_DT,
      CSR_KD_OVER_DT,
      CSR_SAMPLE_TIME_MS,
      CSR_OUT_MIN,
      CSR_OUT_MAX,
      CSR_REVERSE_DIRECTION,
      CSR_P_ON_ERROR
   } csr_index_type;

   localparam logic [STIME_W-1:0]       SAMPLE_TIME_RESET = STIME_W'(100);
   localparam logic signed [DATA_W-1:0] OUT_MIN_RESET     = DATA_W'(-32768);
   localparam logic signed [DATA_W-1:0] OUT_MAX_RESET     = DATA_W'(32767);

   // Scales a limit to the integral's fixed-point format.
   function automatic logic signed [INTEG_W-1:0] limit_scale(
      input logic signed [DATA_W-1:0] lim);
      return {lim, {GAIN_FRAC_BITS{1'b0}}};
   endfunction

   // Tests against the upper limit first, then the lower one.
   function automatic logic signed [INTEG_W-1:0] clamp_limits(
      input logic signed [ACC_W-1:0]   v,
      input logic signed [INTEG_W-1:0] lo,
      input logic signed [INTEG_W-1:0] hi);
      logic signed [ACC_W-1:0] lo_x;
      logic signed [ACC_W-1:0] hi_x;
      lo_x = ACC_W'(lo);
      hi_x = ACC_W'(hi);
      if (v > hi_x) begin
         return hi;
      end else if (v < lo_x) begin
         return lo;
      end
      return v[INTEG_W-1:0];
   endfunction

endpackage

@@ design/pid_controller_clamped_top.sv @@
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_now_ms, req_measurement, req_setpoint
// rsp       out        rsp_valid/rsp_stall  rsp_drive
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// A new transaction can enter on every cycle while req_stall is low; a drive value
// leaves through the five register ranks of the datapath, s1 to s4 and the response rank.
// A request that arrives before the sample time has run out is taken and yields no result.
// Reset is synchronous and active high; it restores the register defaults and state.
// Each rank holds while the rank after it is full and blocked, so a stalled
// response only stops the requests once every rank is occupied.
`include "pid_controller_clamped_top_assert.svh"

module pid_controller_clamped_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [pcc_pkg::TIME_W-1:0]             req_now_ms,
   input  logic signed [pcc_pkg::DATA_W-1:0]      req_measurement,
   input  logic signed [pcc_pkg::DATA_W-1:0]      req_setpoint,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pcc_pkg::DATA_W-1:0]      rsp_drive,
   input  logic                                   csr_write_enable,
   input  logic [pcc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pcc_pkg::CSR_DATA_W-1:0]         csr_write_data
);
   import pcc_pkg::*;

   localparam logic [INTEG_W:0] ROUND_HALF = (INTEG_W + 1)'(1) << (GAIN_FRAC_BITS - 1);

   // Configuration registers.
   logic signed [GAIN_W-1:0]  kp_ff;
   logic signed [GAIN_W-1:0]  ki_times_dt_ff;
   logic signed [GAIN_W-1:0]  kd_over_dt_ff;
   logic [STIME_W-1:0]        sample_time_ms_ff;
   logic signed [DATA_W-1:0]  out_min_ff;
   logic signed [DATA_W-1:0]  out_max_ff;
   logic                      reverse_direction_ff;
   logic                      p_on_error_ff;

   // Controller state.
   logic [TIME_W-1:0]         last_update_ms_ff;
   logic [TIME_W-1:0]         last_update_ms_in;
   logic signed [DATA_W-1:0]  prev_meas_ff;
   logic signed [DATA_W-1:0]  prev_meas_in;
   logic signed [INTEG_W-1:0] integral_ff;
   logic signed [INTEG_W-1:0] integral_in;

   // Pipeline ranks.
   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                      s1_valid_in;
   logic signed [DIFF_W-1:0]  s1_err_ff, s1_err_in;
   logic signed [DIFF_W-1:0]  s1_delta_ff, s1_delta_in;
   logic signed [PROD_W-1:0]  s2_ki_err_ff, s2_kp_delta_ff, s2_kd_delta_ff, s2_kp_err_ff;
   logic signed [PROD_W-1:0]  s2_ki_err_in, s2_kp_delta_in, s2_kd_delta_in, s2_kp_err_in;
   logic signed [SUM_W-1:0]   s3_inc_ff, s3_inc_in;
   logic signed [SUM_W-1:0]   s3_pd_ff, s3_pd_in;
   logic signed [SUM_W-1:0]   s4_pd_ff;
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_drive_ff, rsp_drive_in;

   logic                      out_ready, s4_ready, s3_ready, s2_ready, s1_ready;
   logic                      req_accept;
   logic                      update_due;
   logic [TIME_W-1:0]         elapsed_ms;
   logic signed [DIFF_W-1:0]  err_raw, delta_raw;
   logic signed [INTEG_W-1:0] lim_lo, lim_hi;
   logic signed [INTEG_W-1:0] acc_clamped;
   logic [INTEG_W:0]          acc_rounded;

   // Each rank moves on when it is empty or the rank after it moves on.
   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      s4_ready  = !s4_valid_ff || out_ready;
      s3_ready  = !s3_valid_ff || s4_ready;
      s2_ready  = !s2_valid_ff || s3_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
   end

   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && !req_stall;
   assign lim_lo     = limit_scale(out_min_ff);
   assign lim_hi     = limit_scale(out_max_ff);

   // The elapsed time wraps modulo 2^32, so a plain subtraction is enough.
   always_comb begin
      elapsed_ms        = req_now_ms - last_update_ms_ff;
      update_due        = !(elapsed_ms < TIME_W'(sample_time_ms_ff));
      s1_valid_in       = req_accept && update_due;
      last_update_ms_in = s1_valid_in ? req_now_ms : last_update_ms_ff;
      prev_meas_in      = s1_valid_in ? req_measurement : prev_meas_ff;
      err_raw           = DIFF_W'(req_setpoint) - DIFF_W'(req_measurement);
      delta_raw         = DIFF_W'(prev_meas_ff) - DIFF_W'(req_measurement);
      s1_err_in         = reverse_direction_ff ? -err_raw : err_raw;
      s1_delta_in       = reverse_direction_ff ? -delta_raw : delta_raw;
   end

   // Every product is exact: a 32-bit gain times a 17-bit difference.
   always_comb begin
      s2_ki_err_in   = ki_times_dt_ff * s1_err_ff;
      s2_kp_delta_in = kp_ff * s1_delta_ff;
      s2_kd_delta_in = kd_over_dt_ff * s1_delta_ff;
      s2_kp_err_in   = kp_ff * s1_err_ff;
   end

   // With the proportional terms disabled, kp drops out of both sums.
   always_comb begin
      s3_inc_in = SUM_W'(s2_ki_err_ff);
      s3_pd_in  = SUM_W'(s2_kd_delta_ff);
      if (p_on_error_ff) begin
         s3_inc_in = s3_inc_in + SUM_W'(s2_kp_delta_ff);
         s3_pd_in  = s3_pd_in + SUM_W'(s2_kp_err_ff);
      end
   end

   // The integral changes once per update, as its transaction enters the
   // fourth rank, and holds until that transaction has left it again.
   assign integral_in = clamp_limits(ACC_W'(integral_ff) + ACC_W'(s3_inc_ff), lim_lo, lim_hi);

   // The output is clamped, then rounded to nearest with halves going up.
   always_comb begin
      acc_clamped  = clamp_limits(ACC_W'(s4_pd_ff) + ACC_W'(integral_ff), lim_lo, lim_hi);
      acc_rounded  = (INTEG_W + 1)'(acc_clamped) + ROUND_HALF;
      rsp_drive_in = acc_rounded[INTEG_W-1:GAIN_FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff                <= '0;
         ki_times_dt_ff       <= '0;
         kd_over_dt_ff        <= '0;
         sample_time_ms_ff    <= SAMPLE_TIME_RESET;
         out_min_ff           <= OUT_MIN_RESET;
         out_max_ff           <= OUT_MAX_RESET;
         reverse_direction_ff <= 1'b0;
         p_on_error_ff        <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KP:                kp_ff <= csr_write_data[GAIN_W-1:0];
            CSR_KI_TIMES_DT:       ki_times_dt_ff <= csr_write_data[GAIN_W-1:0];
            CSR_KD_OVER_DT:        kd_over_dt_ff <= csr_write_data[GAIN_W-1:0];
            CSR_SAMPLE_TIME_MS:    sample_time_ms_ff <= csr_write_data[STIME_W-1:0];
            CSR_OUT_MIN:           out_min_ff <= csr_write_data[DATA_W-1:0];
            CSR_OUT_MAX:           out_max_ff <= csr_write_data[DATA_W-1:0];
            CSR_REVERSE_DIRECTION: reverse_direction_ff <= csr_write_data[0];
            CSR_P_ON_ERROR:        p_on_error_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_update_ms_ff <= '0;
         prev_meas_ff      <= '0;
         integral_ff       <= '0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         s3_valid_ff       <= 1'b0;
         s4_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         last_update_ms_ff <= last_update_ms_in;
         prev_meas_ff      <= prev_meas_in;
         if (s1_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
            if (s3_valid_ff) begin
               integral_ff <= integral_in;
            end
         end
         if (out_ready) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_err_ff   <= s1_err_in;
         s1_delta_ff <= s1_delta_in;
      end
      if (s2_ready) begin
         s2_ki_err_ff   <= s2_ki_err_in;
         s2_kp_delta_ff <= s2_kp_delta_in;
         s2_kd_delta_ff <= s2_kd_delta_in;
         s2_kp_err_ff   <= s2_kp_err_in;
      end
      if (s3_ready) begin
         s3_inc_ff <= s3_inc_in;
         s3_pd_ff  <= s3_pd_in;
      end
      if (s4_ready) begin
         s4_pd_ff <= s3_pd_ff;
      end
      if (out_ready) begin
         rsp_drive_ff <= rsp_drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   `PCC_ASSERT(a_early_request_dropped, clock, reset,
      req_accept && !update_due |=> !s1_valid_ff,
      "a request before the sample time entered the pipeline")

   `PCC_ASSERT(a_integral_held, clock, reset,
      s4_valid_ff && rsp_valid_ff && rsp_stall |=> $stable(integral_ff),
      "integral changed while its transaction was held")

   `PCC_ASSERT(a_free_output_takes_request, clock, reset,
      !rsp_valid_ff |-> !req_stall,
      "requests stalled with an empty response register")

   `PCC_ASSERT_ALWAYS(a_reset_empties, clock,
      $past(reset) |-> !s1_valid_ff && !s4_valid_ff && !rsp_valid_ff && integral_ff == '0,
      "pipeline or integral not cleared by reset")

endmodule
